/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the tone generator; only the top file includes them.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/nstg_pkg.sv */
// Package of the note sine tone generator: payload types, constants, tables
// and the elaboration-time sine table function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nstg_pkg;

   localparam int NSTG_PHASE_BITS       = 32;
   localparam int NSTG_SINE_TABLE_DEPTH = 256;
   localparam int NSTG_MAX_OCTAVE       = 8;

   localparam int NSTG_BASE_BITS  = 24;
   localparam int NSTG_LEN_BITS   = 16;
   localparam int NSTG_RATIO_BITS = 17;
   localparam int NSTG_FRAC_BITS  = 16;
   localparam int NSTG_SEMI_BITS  = 4;
   localparam int NSTG_SHIFT_BITS = 4;
   localparam int NSTG_NUM_SEMI   = 12;
   localparam int NSTG_QUEUE_DEPTH = 4;
   localparam int NSTG_CSR_INDEX_BITS = 2;

   localparam logic [NSTG_BASE_BITS-1:0] NSTG_BASE_RESET = 24'd5356535;
   localparam logic [NSTG_LEN_BITS-1:0]  NSTG_LEN_RESET  = 16'd44100;
   localparam logic [7:0]  NSTG_DIGIT_ZERO  = 8'h30;
   localparam logic [15:0] NSTG_SAMPLE_SCALE = 16'd24576;
   localparam logic [63:0] NSTG_HALF_PI_Q30 = 64'd1686629713;

   // Register indexes of the configuration port.
   localparam logic [NSTG_CSR_INDEX_BITS-1:0] CSR_BASE_STEP   = 2'd0;
   localparam logic [NSTG_CSR_INDEX_BITS-1:0] CSR_NOTE_LENGTH = 2'd1;

   // Sharp byte in the upper half, letter in the lower half.
   localparam logic [15:0] NSTG_SEMI_CODE [NSTG_NUM_SEMI] = '{
      16'h0041, 16'h2341, 16'h0042, 16'h0043, 16'h2343, 16'h0044,
      16'h2344, 16'h0045, 16'h0046, 16'h2346, 16'h0047, 16'h2347
   };

   typedef struct packed {
      logic       command;
      logic [7:0] octave_char;
      logic [7:0] note_letter;
      logic [7:0] sharp_char;
   } nstg_req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_of_note;
   } nstg_rsp_type;

   typedef struct packed {
      logic                       is_tick;
      logic [NSTG_SEMI_BITS-1:0]  semi;
      logic [NSTG_SHIFT_BITS-1:0] shift;
   } nstg_cmd_type;

   typedef struct packed {
      logic         valid;
      nstg_cmd_type cmd;
   } nstg_qout_type;

   typedef struct packed {
      logic                           valid;
      logic [NSTG_CSR_INDEX_BITS-1:0] index;
      logic [NSTG_BASE_BITS-1:0]      data;
   } nstg_csr_type;

   // Q1.16 frequency ratio of each semitone above A.
   function automatic logic [NSTG_RATIO_BITS-1:0] nstg_ratio(
      input logic [NSTG_SEMI_BITS-1:0] semi);
      logic [NSTG_RATIO_BITS-1:0] r;
      case (semi)
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73563;
         4'd3:    r = 17'd77935;
         4'd4:    r = 17'd82571;
         4'd5:    r = 17'd87481;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // Next odd power of x in Q30, truncating after each product.
   function automatic logic [63:0] nstg_taylor_term(input logic [63:0] t,
                                                    input logic [63:0] x);
      logic [63:0] p;
      p = (t * x) >> 30;
      p = (p * x) >> 30;
      return p;
   endfunction

   // Quarter-wave table entry for angle x in Q30; used only on constants.
   function automatic logic [15:0] nstg_sine_entry(input logic [63:0] x);
      logic [63:0] t;
      longint      s;
      logic [63:0] v;
      t = x;
      s = longint'(x);
      t = nstg_taylor_term(t, x) / 64'd6;   s = s - longint'(t);
      t = nstg_taylor_term(t, x) / 64'd20;  s = s + longint'(t);
      t = nstg_taylor_term(t, x) / 64'd42;  s = s - longint'(t);
      t = nstg_taylor_term(t, x) / 64'd72;  s = s + longint'(t);
      t = nstg_taylor_term(t, x) / 64'd110; s = s - longint'(t);
      t = nstg_taylor_term(t, x) / 64'd156; s = s + longint'(t);
      t = nstg_taylor_term(t, x) / 64'd210; s = s - longint'(t);
      if (s < 0) begin
         s = 0;
      end
      v = (64'(s) * 64'(NSTG_SAMPLE_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(NSTG_SAMPLE_SCALE)) begin
         v = 64'(NSTG_SAMPLE_SCALE);
      end
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/nstg_front.sv */
// Front end: classifies each input item into a tick or a note load with a
// semitone index and an octave shift. Depends on nstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nstg_front import nstg_pkg::*; #(
   parameter int MAX_OCTAVE = NSTG_MAX_OCTAVE
) (
   input  nstg_req_type req,
   output nstg_cmd_type cmd
);

   logic [15:0] code;
   logic        found;
   logic [NSTG_SEMI_BITS-1:0] semi;
   logic [7:0]  octave;

   always_comb begin
      code  = {req.sharp_char, req.note_letter};
      found = 1'b0;
      semi  = '0;
      for (int i = 0; i < NSTG_NUM_SEMI; i++) begin
         if (NSTG_SEMI_CODE[i] == code) begin
            found = 1'b1;
            semi  = NSTG_SEMI_BITS'(i);
         end
      end

      // An unknown note plays A at the base octave.
      octave = 8'd0;
      if (found && (req.octave_char >= NSTG_DIGIT_ZERO)) begin
         octave = req.octave_char - NSTG_DIGIT_ZERO;
      end
      if (octave > 8'(MAX_OCTAVE)) begin
         octave = 8'(MAX_OCTAVE);
      end

      cmd.is_tick = req.command;
      cmd.semi    = semi;
      cmd.shift   = (octave > 8'd1) ? NSTG_SHIFT_BITS'(octave - 8'd1) : '0;
   end

endmodule

`default_nettype wire

/* rtl/nstg_queue.sv */
// Short command queue between the front end and the back end, so that each
// side stalls on its own. Depends on nstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nstg_queue import nstg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  nstg_cmd_type  push_cmd,
   output logic          full,
   input  logic          pop,
   output nstg_qout_type head
);

   localparam int PtrBits   = $clog2(NSTG_QUEUE_DEPTH);
   localparam int CountBits = $clog2(NSTG_QUEUE_DEPTH + 1);

   nstg_cmd_type             entry_ff [NSTG_QUEUE_DEPTH];
   logic [PtrBits-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]     count_ff, count_in;
   logic                     push;

   assign full = (count_ff == CountBits'(NSTG_QUEUE_DEPTH));
   assign push = push_valid && !full;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff + CountBits'(push) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/nstg_back.sv */
// Back end: step multiply, phase/note state update and sine table lookup,
// plus the configuration registers. Depends on nstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nstg_back import nstg_pkg::*; #(
   parameter int PHASE_BITS       = NSTG_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = NSTG_SINE_TABLE_DEPTH,
   parameter int MAX_OCTAVE       = NSTG_MAX_OCTAVE
) (
   input  logic          clock,
   input  logic          reset,
   input  nstg_csr_type  csr,
   input  nstg_qout_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output nstg_rsp_type  rsp_payload
);

   localparam int ProdBits  = NSTG_BASE_BITS + NSTG_RATIO_BITS;
   localparam int ShiftW    = ProdBits + MAX_OCTAVE - 1;
   localparam int RoundW    = ShiftW + 1 - NSTG_FRAC_BITS;
   localparam int SatW      = ((RoundW > PHASE_BITS) ? RoundW : PHASE_BITS) + 1;
   localparam int IdxW      = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int RemW      = $clog2(SINE_TABLE_DEPTH);
   localparam int TabW      = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [IdxW:0]   IdxMult = (IdxW + 1)'(4 * SINE_TABLE_DEPTH);
   localparam logic [IdxW-1:0] Quarter1 = IdxW'(SINE_TABLE_DEPTH);
   localparam logic [IdxW-1:0] Quarter2 = IdxW'(2 * SINE_TABLE_DEPTH);
   localparam logic [IdxW-1:0] Quarter3 = IdxW'(3 * SINE_TABLE_DEPTH);

   // Quarter-wave sine table, worked out at elaboration.
   logic [15:0] quarter_wave [SINE_TABLE_DEPTH + 1];
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_wave
      localparam logic [63:0] WaveX =
         (64'(k) * NSTG_HALF_PI_Q30) / SINE_TABLE_DEPTH;
      assign quarter_wave[k] = nstg_sine_entry(WaveX);
   end

   logic [NSTG_BASE_BITS-1:0] base_ff, base_in;
   logic [NSTG_LEN_BITS-1:0]  len_ff, len_in;

   logic                      s1_valid_ff, s1_valid_in;
   nstg_cmd_type              s1_cmd_ff, s1_cmd_in;
   logic [ProdBits-1:0]       s1_prod_ff, s1_prod_in;

   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [PHASE_BITS-1:0]     step_ff, step_in;
   logic [NSTG_LEN_BITS-1:0]  count_ff, count_in;
   logic                      active_ff, active_in;

   logic                      s2_valid_ff, s2_valid_in;
   logic [IdxW-1:0]           s2_idx_ff, s2_idx_in;
   logic                      s2_last_ff, s2_last_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   nstg_rsp_type              rsp_ff, rsp_in;

   logic                      adv;
   logic [ShiftW-1:0]         shifted;
   logic [ShiftW:0]           round_sum;
   logic [SatW-1:0]           round_ext;
   logic [PHASE_BITS-1:0]     new_step;
   logic [NSTG_LEN_BITS-1:0]  limit;
   logic [NSTG_LEN_BITS-1:0]  count_next;
   logic [PHASE_BITS+IdxW:0]  idx_prod;
   logic [1:0]                quarter;
   logic [IdxW-1:0]           quarter_base;
   logic [IdxW-1:0]           rem_full;
   logic [RemW-1:0]           rem;
   logic [TabW-1:0]           tab_idx;
   logic [15:0]               mag;

   // The whole back end moves together whenever the output register frees.
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head.valid;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      // Step of a loaded note: product shifted by octave, rounded, saturated.
      shifted   = ShiftW'(s1_prod_ff) << s1_cmd_ff.shift;
      round_sum = {1'b0, shifted} + (ShiftW + 1)'(1 << (NSTG_FRAC_BITS - 1));
      round_ext = SatW'(round_sum[ShiftW:NSTG_FRAC_BITS]);
      new_step  = (round_ext > SatW'({PHASE_BITS{1'b1}})) ? '1
                                                         : round_ext[PHASE_BITS-1:0];

      limit      = (len_ff == '0) ? NSTG_LEN_BITS'(1) : len_ff;
      count_next = count_ff + NSTG_LEN_BITS'(1);
      idx_prod   = (PHASE_BITS + IdxW + 1)'(phase_ff) * (PHASE_BITS + IdxW + 1)'(IdxMult);

      // Fold the table index into one quarter and pick the mirror and sign.
      if (s2_idx_ff >= Quarter3) begin
         quarter      = 2'd3;
         quarter_base = Quarter3;
      end else if (s2_idx_ff >= Quarter2) begin
         quarter      = 2'd2;
         quarter_base = Quarter2;
      end else if (s2_idx_ff >= Quarter1) begin
         quarter      = 2'd1;
         quarter_base = Quarter1;
      end else begin
         quarter      = 2'd0;
         quarter_base = '0;
      end
      rem_full = s2_idx_ff - quarter_base;
      rem      = rem_full[RemW-1:0];
      tab_idx  = quarter[0] ? TabW'(SINE_TABLE_DEPTH) - TabW'(rem) : TabW'(rem);
      mag      = quarter_wave[tab_idx];
   end

   always_comb begin
      base_in      = base_ff;
      len_in       = len_ff;
      s1_valid_in  = s1_valid_ff;
      s1_cmd_in    = s1_cmd_ff;
      s1_prod_in   = s1_prod_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      s2_valid_in  = s2_valid_ff;
      s2_idx_in    = s2_idx_ff;
      s2_last_in   = s2_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr.valid) begin
         case (csr.index)
            CSR_BASE_STEP:   base_in = csr.data;
            CSR_NOTE_LENGTH: len_in  = csr.data[NSTG_LEN_BITS-1:0];
            default:         ;
         endcase
      end

      if (adv) begin
         s1_valid_in = pop;
         s1_cmd_in   = head.cmd;
         s1_prod_in  = ProdBits'(base_ff) * ProdBits'(nstg_ratio(head.cmd.semi));

         s2_valid_in = 1'b0;
         s2_idx_in   = idx_prod[PHASE_BITS+IdxW-1:PHASE_BITS];
         s2_last_in  = (count_next >= limit);
         if (s1_valid_ff) begin
            if (!s1_cmd_ff.is_tick) begin
               step_in   = new_step;
               phase_in  = '0;
               count_in  = '0;
               active_in = 1'b1;
            end else if (active_ff) begin
               // A tick with no note playing leaves no result.
               s2_valid_in = 1'b1;
               phase_in    = phase_ff + step_ff;
               count_in    = count_next;
               active_in   = !(count_next >= limit);
            end
         end

         rsp_valid_in        = s2_valid_ff;
         rsp_in.sample       = quarter[1] ? $signed(16'd0 - mag) : $signed(mag);
         rsp_in.last_of_note = s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= NSTG_BASE_RESET;
         len_ff       <= NSTG_LEN_RESET;
         s1_valid_ff  <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         len_ff       <= len_in;
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= s1_cmd_in;
      s1_prod_ff <= s1_prod_in;
      s2_idx_ff  <= s2_idx_in;
      s2_last_ff <= s2_last_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

/* rtl/note_sine_tone_generator.sv */
// Note sine tone generator: front end classifier, command queue, back end.
// An accepted tick reaches rsp through the queue, the step multiply stage, the phase
// stage and the table stage; throughput is one item per cycle while rsp_stall is low.
// A load item yields no result; its step is ready for the tick behind it.
// Reset is synchronous and active high: queue, pipeline and note state clear,
// configuration registers return to their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module note_sine_tone_generator import nstg_pkg::*; #(
   parameter int PHASE_BITS       = NSTG_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = NSTG_SINE_TABLE_DEPTH,
   parameter int MAX_OCTAVE       = NSTG_MAX_OCTAVE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nstg_req_type                   req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output nstg_rsp_type                   rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [NSTG_CSR_INDEX_BITS-1:0] csr_index,
   input  logic [NSTG_BASE_BITS-1:0]      csr_data
);

   nstg_cmd_type  front_cmd;
   nstg_qout_type head;
   nstg_csr_type  csr;
   logic          queue_full;
   logic          pop;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;
   assign req_stall = queue_full;

   nstg_front #(
      .MAX_OCTAVE (MAX_OCTAVE)
   ) u_front (
      .req (req_payload),
      .cmd (front_cmd)
   );

   nstg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   nstg_back #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .MAX_OCTAVE       (MAX_OCTAVE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The back end never takes a command from an empty queue.
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, head.valid)
   // Nothing is popped while a finished sample is held by the consumer.
   `ASSERT_IMPLIES(a_pop_not_blocked, clock, reset, pop, !(rsp_valid && rsp_stall))
   // An accepted item is waiting in the queue on the next cycle.
   `ASSERT_NEXT(a_push_lands, clock, reset, req_valid && !req_stall, head.valid)
   // Samples stay within the scaled sine range.
   `ASSERT_IMPLIES(a_sample_range, clock, reset, rsp_valid,
                   (rsp_payload.sample <= 16'sd24576) && (rsp_payload.sample >= -16'sd24576))

endmodule

`default_nettype wire

/* tb/sv/note_sine_tone_checker.sv */
// Checker of the note sine tone generator: it watches the request, response and
// register channels, predicts every sample and compares it with the block's output.
// Depends on nstg_pkg for the payload types and the register indexes.
`timescale 1ns / 1ps

module note_sine_tone_checker import nstg_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  nstg_req_type                   req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  nstg_rsp_type                   rsp_payload,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [NSTG_CSR_INDEX_BITS-1:0] csr_index,
   input  logic [NSTG_BASE_BITS-1:0]      csr_data,
   output int                             error_count,
   output int                             pending_count
);

   localparam int DEPTH = NSTG_SINE_TABLE_DEPTH;
   localparam logic [63:0] STEP_CEILING = (64'd1 << NSTG_PHASE_BITS) - 64'd1;

   // Note keys: sharp byte above the letter byte, in semitone order from A.
   localparam logic [15:0] NOTE_KEY [12] = '{
      16'h0041, 16'h2341, 16'h0042, 16'h0043, 16'h2343, 16'h0044,
      16'h2344, 16'h0045, 16'h0046, 16'h2346, 16'h0047, 16'h2347
   };
   localparam logic [16:0] NOTE_RATIO [12] = '{
      17'd65536, 17'd69433, 17'd73563, 17'd77935, 17'd82571, 17'd87481,
      17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
   };

   logic [15:0]                 quarter_wave [0:DEPTH];
   logic [NSTG_BASE_BITS-1:0]   base_step;
   logic [NSTG_LEN_BITS-1:0]    note_len;
   logic [NSTG_PHASE_BITS-1:0]  tone_phase;
   logic [NSTG_PHASE_BITS-1:0]  tone_step;
   logic [15:0]                 emitted;
   logic                        playing;
   nstg_rsp_type                expected_samples [$];

   // Truncated Taylor sum of sin(x) in Q30, scaled to the sample amplitude.
   function automatic logic [15:0] quarter_amplitude(input int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      int          n;
      x = (64'(k) * NSTG_HALF_PI_Q30) / 64'(DEPTH);
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'(NSTG_SAMPLE_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(NSTG_SAMPLE_SCALE)) begin
         v = 64'(NSTG_SAMPLE_SCALE);
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] sine_sample(input logic [NSTG_PHASE_BITS-1:0] ph);
      logic [63:0] idx;
      logic [63:0] quarter;
      logic [63:0] rem;
      logic [15:0] mag;
      idx = (64'(ph) * 64'(4 * DEPTH)) >> NSTG_PHASE_BITS;
      quarter = idx / 64'(DEPTH);
      rem = idx % 64'(DEPTH);
      // Odd quarters run the table backward, the upper half wave is negative.
      mag = quarter[0] ? quarter_wave[DEPTH - int'(rem)] : quarter_wave[int'(rem)];
      return quarter[1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [NSTG_PHASE_BITS-1:0] note_step(input logic [7:0] oct_char,
                                                             input logic [7:0] letter,
                                                             input logic [7:0] sharp);
      logic [15:0] key;
      int          semi;
      int          octave;
      bit          known;
      logic [63:0] prod;
      key = {sharp, letter};
      semi = 0;
      octave = 0;
      known = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (NOTE_KEY[i] == key) begin
            semi = i;
            known = 1'b1;
         end
      end
      // An unknown note plays A in the base octave whatever the digit says.
      if (known) begin
         octave = (oct_char >= NSTG_DIGIT_ZERO) ? int'(oct_char - NSTG_DIGIT_ZERO) : 0;
         if (octave > NSTG_MAX_OCTAVE) begin
            octave = NSTG_MAX_OCTAVE;
         end
      end
      prod = 64'(base_step) * 64'(NOTE_RATIO[semi]);
      if (octave > 1) begin
         prod = prod << (octave - 1);
      end
      prod = (prod + 64'd32768) >> NSTG_FRAC_BITS;
      if (prod > STEP_CEILING) begin
         prod = STEP_CEILING;
      end
      return prod[NSTG_PHASE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      for (int k = 0; k <= DEPTH; k++) begin
         quarter_wave[k] = quarter_amplitude(k);
      end
   end

   always @(posedge clock) begin
      nstg_rsp_type want;
      int           limit;
      if (reset) begin
         error_count = 0;
         base_step = NSTG_BASE_RESET;
         note_len = NSTG_LEN_RESET;
         tone_phase = '0;
         tone_step = '0;
         emitted = '0;
         playing = 1'b0;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_STEP:   base_step = csr_data;
               CSR_NOTE_LENGTH: note_len = csr_data[NSTG_LEN_BITS-1:0];
               default: ;
            endcase
         end
         // Responses are checked before this edge's request is predicted, since
         // no item can come out in the cycle it goes in.
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", int'(rsp_payload.sample), 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.sample !== want.sample) begin
                  report_mismatch("sample", int'(rsp_payload.sample), int'(want.sample));
               end
               if (rsp_payload.last_of_note !== want.last_of_note) begin
                  report_mismatch("last_of_note", int'(rsp_payload.last_of_note),
                                  int'(want.last_of_note));
               end
            end
         end
         if (req_valid && !req_stall) begin
            // A clear command bit loads a note, a set one is a sample tick.
            if (!req_payload.command) begin
               tone_step = note_step(req_payload.octave_char, req_payload.note_letter,
                                     req_payload.sharp_char);
               tone_phase = '0;
               emitted = '0;
               playing = 1'b1;
            end else if (playing) begin
               want.sample = sine_sample(tone_phase);
               tone_phase = tone_phase + tone_step;
               emitted = emitted + 16'd1;
               limit = (note_len == '0) ? 1 : int'(note_len);
               want.last_of_note = (int'(emitted) >= limit);
               if (want.last_of_note) begin
                  playing = 1'b0;
               end
               expected_samples.push_back(want);
            end
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

/* tb/sv/note_sine_tone_generator_tb.sv */
// Top of the note sine tone generator testbench: clock, reset, stimulus, stall
// pattern, watchdog and verdict. Depends on nstg_pkg, the block and note_sine_tone_checker.
`timescale 1ns / 1ps

module note_sine_tone_generator_tb;
   import nstg_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS = 48;
   localparam int RANDOM_PHASES = 8;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic [7:0] SHARP_MARK = 8'h23;
   localparam logic [7:0] NATURAL_MARK = 8'h00;
   localparam logic [7:0] LETTER_A = "A";
   localparam logic [NSTG_CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   nstg_req_type                   req_payload;
   logic                           rsp_valid;
   logic                           rsp_stall;
   nstg_rsp_type                   rsp_payload;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [NSTG_CSR_INDEX_BITS-1:0] csr_index;
   logic [NSTG_BASE_BITS-1:0]      csr_data;
   int                             error_count;
   int                             pending_count;
   bit                             calm_req;

   note_sine_tone_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   note_sine_tone_checker tone_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int idle_cycles(input bit calm);
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic nstg_req_type load_item(input logic [7:0] oct_char,
                                              input logic [7:0] letter,
                                              input logic [7:0] sharp);
      nstg_req_type item;
      item.command = CMD_LOAD;
      item.octave_char = oct_char;
      item.note_letter = letter;
      item.sharp_char = sharp;
      return item;
   endfunction

   // The note fields of a tick are ignored, so they carry noise.
   function automatic nstg_req_type tick_item();
      nstg_req_type item;
      item.command = CMD_TICK;
      item.octave_char = 8'($urandom);
      item.note_letter = 8'($urandom);
      item.sharp_char = 8'($urandom);
      return item;
   endfunction

   // Valid stays high after an item is taken; the next call lowers it only for a gap.
   task automatic send_item(input nstg_req_type item);
      int gap;
      gap = idle_cycles(calm_req);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid, waits for every sample still owed, then lets the pipeline drain
   // behind a trailing load, which has no sample to wait for.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [NSTG_CSR_INDEX_BITS-1:0] index,
                            input logic [NSTG_BASE_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_tone_config(input logic [NSTG_BASE_BITS-1:0] base,
                                  input logic [NSTG_BASE_BITS-1:0] length_word);
      write_reg(CSR_BASE_STEP, base);
      write_reg(CSR_NOTE_LENGTH, length_word);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response stalls: short runs mostly, a few long ones, and stretches with none.
   initial begin
      int run;
      int hold;
      rsp_stall = 1'b0;
      forever begin
         run = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 200) : $urandom_range(1, 12);
         repeat (run) @(negedge clock) rsp_stall <= 1'b0;
         hold = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 50) : $urandom_range(1, 3);
         repeat (hold) @(negedge clock) rsp_stall <= 1'b1;
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int                        r;
      logic [NSTG_BASE_BITS-1:0] base;
      logic [NSTG_BASE_BITS-1:0] length_word;
      nstg_req_type              item;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BASE_STEP;
      csr_data = '0;
      calm_req = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Default registers: a tick before any note gives nothing, then A4.
      send_item(tick_item());
      send_item(load_item("4", "A", NATURAL_MARK));
      repeat (3) send_item(tick_item());
      settle();

      // Largest base step, short notes: the note ends and later ticks are silent.
      set_tone_config({NSTG_BASE_BITS{1'b1}}, 24'd3);
      send_item(load_item("9", "G", SHARP_MARK));
      repeat (4) send_item(tick_item());
      send_item(load_item(NSTG_DIGIT_ZERO - 8'd1, "C", SHARP_MARK));
      send_item(tick_item());
      send_item(load_item("0", "B", NATURAL_MARK));
      send_item(tick_item());
      send_item(load_item(8'hFF, "H", NATURAL_MARK));
      send_item(tick_item());
      send_item(load_item("5", "A", 8'h55));
      send_item(tick_item());
      send_item(load_item("3", "B", SHARP_MARK));
      send_item(tick_item());
      send_item(load_item("1", "E", NATURAL_MARK));
      send_item(tick_item());
      settle();

      // Zero base step and a zero note length, with junk above the length bits.
      set_tone_config('0, 24'h5A0000);
      send_item(load_item("7", "D", NATURAL_MARK));
      repeat (2) send_item(tick_item());

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         r = $urandom_range(0, 99);
         base = (r < 15) ? {NSTG_BASE_BITS{1'b1}} : (r < 25) ? NSTG_BASE_RESET
                : NSTG_BASE_BITS'($urandom);
         r = $urandom_range(0, 99);
         length_word = (r < 15) ? {8'($urandom), 16'hFFFF} : (r < 25) ? '0
                       : (r < 40) ? 24'd1 : NSTG_BASE_BITS'($urandom_range(2, 24));
         if (phase == 3) begin
            write_reg(CSR_UNMAPPED, NSTG_BASE_BITS'($urandom));
         end
         set_tone_config(base, length_word);
         calm_req = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            item = tick_item();
            if (r < 30) begin
               item = load_item(NSTG_DIGIT_ZERO + 8'($urandom_range(0, 9)),
                                LETTER_A + 8'($urandom_range(0, 6)),
                                $urandom_range(0, 1) ? SHARP_MARK : NATURAL_MARK);
            end else if (r < 38) begin
               // Load with arbitrary bytes, mostly an unknown note.
               item.command = CMD_LOAD;
            end
            send_item(item);
         end
      end
      settle();
      repeat (4) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
